// ===== hdl/icbs_pkg.sv =====
package icbs_pkg;

    localparam int CPU_W    = 12;
    localparam int CHOSEN_W = 13;
    localparam int TPC_W    = 3;
    localparam int CALLER_W = 6;
    localparam int HOW_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 3;

    localparam logic [31:0] GOLDEN_MULT = 32'h9E37_79B9;

    localparam int CTR_AW          = CALLER_W;
    localparam int CTR_ENTRIES     = 1 << CTR_AW;
    localparam int CTR_RESET_SHIFT = 24;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SMT_ACTIVE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREADS_PER_CORE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CPU_NUMBER = 2'd2;

    localparam logic [HOW_W-1:0] HOW_TARGET  = 2'd0;
    localparam logic [HOW_W-1:0] HOW_CORE    = 2'd1;
    localparam logic [HOW_W-1:0] HOW_SIBLING = 2'd2;
    localparam logic [HOW_W-1:0] HOW_ANY     = 2'd3;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [CTR_AW-1:0] addr;
        logic [31:0]       wdata;
    } icbs_ctr_req_t;

endpackage

// ===== hdl/idle_cpu_bitmap_selector.sv =====
// Update writes the CPU's idle bit; with SMT on, the remainder unit then finds the sibling
// group and a member scan sets or clears its core bit. Select needs no search when no CPU is
// idle or the target is idle; else it makes a sibling pick or a pseudo-random pick (count, then
// search, one bitmap bit per cycle), the latter also after a failed sibling search. One item
// at a time: input is ready only while idle. Reset clears both bitmaps and sets config to SMT
// off, one thread per core, first CPU 0; pick counters read as index << 24 until written.
module idle_cpu_bitmap_selector
    import icbs_pkg::*;
#(
    parameter int NUM_CPUS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [11:0] cpu_number, [12] now_idle, [13] want_idle_core, [19:14] caller_cpu
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [12:0] chosen_cpu
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] found, [2:1] how_chosen
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int BW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CW = $clog2(NUM_CPUS + 1);
    localparam logic [BW-1:0]       LAST_BIT = BW'(NUM_CPUS - 1);
    localparam logic [CHOSEN_W-1:0] NCPU     = CHOSEN_W'(NUM_CPUS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CTR_INC,
        S_SEED,
        S_GRP_DIV,
        S_MEMBERS,
        S_POP,
        S_MUL2,
        S_PICK,
        S_FIND,
        S_RESULT,
        S_DONE
    } state_t;

    function automatic logic in_map(input logic [CHOSEN_W-1:0] n, input logic [CPU_W-1:0] base);
        logic [CHOSEN_W:0] diff;
        diff = {1'b0, n} - {2'b0, base};
        return !diff[CHOSEN_W] && (diff[CHOSEN_W-1:0] < NCPU);
    endfunction

    function automatic logic [BW-1:0] map_bit(input logic [CHOSEN_W-1:0] n,
                                              input logic [CPU_W-1:0] base);
        logic [CHOSEN_W-1:0] diff;
        diff = n - {1'b0, base};
        return diff[BW-1:0];
    endfunction

    // configuration
    logic             smt_reg;
    logic [TPC_W-1:0] tpc_reg;
    logic [CPU_W-1:0] first_cpu_reg;

    // item and datapath
    state_t                state_reg, state_next;
    logic                  op_reg, op_next;
    logic [CPU_W-1:0]      cpu_reg, cpu_next;
    logic                  now_idle_reg, now_idle_next;
    logic                  want_core_reg, want_core_next;
    logic [CALLER_W-1:0]   caller_reg, caller_next;
    logic [NUM_CPUS-1:0]   cpu_map_reg, cpu_map_next;
    logic [NUM_CPUS-1:0]   core_map_reg, core_map_next;
    logic [CHOSEN_W-1:0]   grp_first_reg, grp_first_next;
    logic [BW-1:0]         cb_reg, cb_next;
    logic [TPC_W-1:0]      mem_i_reg, mem_i_next;
    logic                  all_ok_reg, all_ok_next;
    logic                  use_core_reg, use_core_next;
    logic [31:0]           seed_reg, seed_next;
    logic [CW-1:0]         total_reg, total_next;
    logic [CW-1:0]         pick_reg, pick_next;
    logic [CW-1:0]         seen_reg, seen_next;
    logic [BW-1:0]         idx_reg, idx_next;
    logic [BW-1:0]         res_bit_reg, res_bit_next;
    logic [CHOSEN_W-1:0]   res_chosen_reg, res_chosen_next;
    logic                  res_found_reg, res_found_next;
    logic [HOW_W-1:0]      res_how_reg, res_how_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHOSEN_W-1:0]   out_chosen_reg, out_chosen_next;
    logic                  out_found_reg, out_found_next;
    logic [HOW_W-1:0]      out_how_reg, out_how_next;

    logic [TPC_W-1:0]    t_eff;
    logic [CHOSEN_W-1:0] cpu_ext;
    logic [CHOSEN_W-1:0] first_now;
    logic [CHOSEN_W-1:0] mem_num;
    logic                mem_ok;
    logic [NUM_CPUS-1:0] map_sel;
    logic                in_accept;

    icbs_ctr_req_t ctr_req;
    logic [31:0]   ctr_rdata;
    logic [31:0]   ctr_inc;
    logic          mul_en;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic          rem_start;
    logic          rem_done;
    logic [TPC_W-1:0] rem_val;

    icbs_ctr_ram u_ctr_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ctr_req),
        .rd_data (ctr_rdata)
    );

    icbs_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    icbs_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cpu_reg),
        .divisor  (t_eff),
        .done     (rem_done),
        .rem      (rem_val)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign t_eff     = (tpc_reg == '0) ? TPC_W'(1) : tpc_reg;
    assign cpu_ext   = {1'b0, cpu_reg};
    assign first_now = cpu_ext - CHOSEN_W'(rem_val);
    assign mem_num   = grp_first_reg + CHOSEN_W'(mem_i_reg);
    assign mem_ok    = in_map(mem_num, first_cpu_reg) && cpu_map_reg[map_bit(mem_num, first_cpu_reg)];
    assign map_sel   = use_core_reg ? core_map_reg : cpu_map_reg;
    assign ctr_inc   = ctr_rdata + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smt_reg       <= 1'b0;
            tpc_reg       <= TPC_W'(1);
            first_cpu_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SMT_ACTIVE:       smt_reg       <= cfg_data[0];
                CFG_THREADS_PER_CORE: tpc_reg       <= cfg_data[TPC_W-1:0];
                CFG_FIRST_CPU_NUMBER: first_cpu_reg <= cfg_data[CPU_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cpu_next        = cpu_reg;
        now_idle_next   = now_idle_reg;
        want_core_next  = want_core_reg;
        caller_next     = caller_reg;
        cpu_map_next    = cpu_map_reg;
        core_map_next   = core_map_reg;
        grp_first_next  = grp_first_reg;
        cb_next         = cb_reg;
        mem_i_next      = mem_i_reg;
        all_ok_next     = all_ok_reg;
        use_core_next   = use_core_reg;
        seed_next       = seed_reg;
        total_next      = total_reg;
        pick_next       = pick_reg;
        seen_next       = seen_reg;
        idx_next        = idx_reg;
        res_bit_next    = res_bit_reg;
        res_chosen_next = res_chosen_reg;
        res_found_next  = res_found_reg;
        res_how_next    = res_how_reg;
        out_valid_next  = out_valid_reg;
        out_chosen_next = out_chosen_reg;
        out_found_next  = out_found_reg;
        out_how_next    = out_how_reg;

        ctr_req       = '0;
        ctr_req.addr  = caller_reg;
        ctr_req.wdata = ctr_inc;
        mul_en        = 1'b0;
        mul_a         = ctr_inc;
        mul_b         = GOLDEN_MULT;
        rem_start     = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next         = s_axis_tuser[0];
                    cpu_next        = s_axis_tdata[11:0];
                    now_idle_next   = s_axis_tdata[12];
                    want_core_next  = s_axis_tdata[13];
                    caller_next     = s_axis_tdata[19:14];
                    res_chosen_next = '0;
                    res_found_next  = 1'b0;
                    res_how_next    = HOW_TARGET;
                    res_bit_next    = '0;
                    state_next      = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                if (op_reg == OP_UPDATE)
                begin
                    state_next = S_DONE;
                    if (in_map(cpu_ext, first_cpu_reg))
                    begin
                        cpu_map_next[map_bit(cpu_ext, first_cpu_reg)] = now_idle_reg;
                        if (smt_reg)
                        begin
                            rem_start  = 1'b1;
                            state_next = S_GRP_DIV;
                        end
                    end
                end
                else if (|cpu_map_reg)
                begin
                    res_found_next = 1'b1;
                    if (in_map(cpu_ext, first_cpu_reg)
                        && cpu_map_reg[map_bit(cpu_ext, first_cpu_reg)])
                    begin
                        res_chosen_next = cpu_ext;
                        res_how_next    = HOW_TARGET;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ctr_req.rd_en = 1'b1;
                        state_next    = S_CTR_INC;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_CTR_INC:
            begin
                ctr_req.wr_en = 1'b1;
                mul_en        = 1'b1;
                state_next    = S_SEED;
            end

            S_SEED:
            begin
                seed_next  = mul_p[31:0];
                idx_next   = '0;
                total_next = '0;
                if (want_core_reg && smt_reg && (|core_map_reg))
                begin
                    use_core_next = 1'b1;
                    res_how_next  = HOW_CORE;
                    state_next    = S_POP;
                end
                else if (want_core_reg && smt_reg)
                begin
                    rem_start  = 1'b1;
                    state_next = S_GRP_DIV;
                end
                else
                begin
                    use_core_next = 1'b0;
                    res_how_next  = HOW_ANY;
                    state_next    = S_POP;
                end
            end

            S_GRP_DIV:
            begin
                if (rem_done)
                begin
                    grp_first_next = first_now;
                    cb_next        = map_bit(first_now, first_cpu_reg);
                    mem_i_next     = '0;
                    all_ok_next    = 1'b1;
                    // core bit untouched when the group's first CPU has no bit
                    if (op_reg == OP_UPDATE && !in_map(first_now, first_cpu_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MEMBERS;
                    end
                end
            end

            S_MEMBERS:
            begin
                mem_i_next = mem_i_reg + 1'b1;
                if (op_reg == OP_UPDATE)
                begin
                    all_ok_next = all_ok_reg && mem_ok;
                    if (mem_i_reg == t_eff - 1'b1)
                    begin
                        core_map_next[cb_reg] = now_idle_reg && all_ok_reg && mem_ok;
                        state_next            = S_DONE;
                    end
                end
                else if (mem_ok)
                begin
                    res_bit_next = map_bit(mem_num, first_cpu_reg);
                    res_how_next = HOW_SIBLING;
                    state_next   = S_RESULT;
                end
                else if (mem_i_reg == t_eff - 1'b1)
                begin
                    // no idle sibling: fall back to any idle CPU
                    use_core_next = 1'b0;
                    res_how_next  = HOW_ANY;
                    idx_next      = '0;
                    total_next    = '0;
                    state_next    = S_POP;
                end
            end

            S_POP:
            begin
                total_next = total_reg + CW'(map_sel[idx_reg]);
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == LAST_BIT)
                begin
                    state_next = S_MUL2;
                end
            end

            S_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = seed_reg;
                mul_b      = 32'(total_reg);
                state_next = S_PICK;
            end

            S_PICK:
            begin
                pick_next  = mul_p[32 +: CW];
                idx_next   = '0;
                seen_next  = '0;
                state_next = S_FIND;
            end

            S_FIND:
            begin
                idx_next = idx_reg + 1'b1;
                if (map_sel[idx_reg])
                begin
                    seen_next = seen_reg + 1'b1;
                end
                if (map_sel[idx_reg] && seen_reg == pick_reg)
                begin
                    res_bit_next = idx_reg;
                    state_next   = S_RESULT;
                end
                else if (idx_reg == LAST_BIT)
                begin
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                res_chosen_next = CHOSEN_W'(res_bit_reg) + {1'b0, first_cpu_reg};
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = res_chosen_reg;
                    out_found_next  = res_found_reg;
                    out_how_next    = res_how_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cpu_map_reg    <= '0;
            core_map_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_chosen_reg <= '0;
            out_found_reg  <= 1'b0;
            out_how_reg    <= HOW_TARGET;
        end
        else
        begin
            state_reg      <= state_next;
            cpu_map_reg    <= cpu_map_next;
            core_map_reg   <= core_map_next;
            out_valid_reg  <= out_valid_next;
            out_chosen_reg <= out_chosen_next;
            out_found_reg  <= out_found_next;
            out_how_reg    <= out_how_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cpu_reg        <= cpu_next;
        now_idle_reg   <= now_idle_next;
        want_core_reg  <= want_core_next;
        caller_reg     <= caller_next;
        grp_first_reg  <= grp_first_next;
        cb_reg         <= cb_next;
        mem_i_reg      <= mem_i_next;
        all_ok_reg     <= all_ok_next;
        use_core_reg   <= use_core_next;
        seed_reg       <= seed_next;
        total_reg      <= total_next;
        pick_reg       <= pick_next;
        seen_reg       <= seen_next;
        idx_reg        <= idx_next;
        res_bit_reg    <= res_bit_next;
        res_chosen_reg <= res_chosen_next;
        res_found_reg  <= res_found_next;
        res_how_reg    <= res_how_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_chosen_reg);
    assign m_axis_tuser  = {out_how_reg, out_found_reg};

`ifndef SYNTHESIS
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && m_axis_tuser == '0))
        else $error("result without a find carries nonzero fields");

    a_find_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) |-> (pick_reg < total_reg && seen_reg <= pick_reg))
        else $error("set-bit search passed its pick");

    a_rem_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (state_reg == S_GRP_DIV))
        else $error("remainder finished outside group lookup");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_DISPATCH))
        else $error("accepted transaction not dispatched");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (|map_sel))
        else $error("pseudo-random pick over an empty bitmap");
`endif

endmodule

// ===== hdl/icbs_mul.sv =====
module icbs_mul
    import icbs_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= 64'(a) * 64'(b);
        end
    end

    assign p = p_reg;

endmodule

// ===== hdl/icbs_rem.sv =====
module icbs_rem
    import icbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CPU_W-1:0] dividend,
    input  logic [TPC_W-1:0] divisor,
    output logic             done,
    output logic [TPC_W-1:0] rem
);

    localparam int CNT_W = $clog2(CPU_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CPU_W-1:0] shift_reg;
    logic [TPC_W-1:0] part_reg;
    logic [TPC_W:0]   trial;
    logic [TPC_W:0]   diff;

    // one quotient bit per cycle, restoring
    assign trial = {part_reg, shift_reg[CPU_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CPU_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            part_reg  <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[CPU_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                part_reg <= diff[TPC_W-1:0];
            end
            else
            begin
                part_reg <= trial[TPC_W-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = part_reg;

endmodule

// ===== hdl/icbs_ctr_ram.sv =====
module icbs_ctr_ram
    import icbs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  icbs_ctr_req_t req,
    output logic [31:0]   rd_data
);

    logic [31:0]            mem [CTR_ENTRIES];
    logic [CTR_ENTRIES-1:0] vld_reg;
    logic [31:0]            rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
    end

    // entries never written read as their reset seed
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (vld_reg[req.addr])
            begin
                rd_data_reg <= mem[req.addr];
            end
            else
            begin
                rd_data_reg <= 32'(req.addr) << CTR_RESET_SHIFT;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
